/* hw/rtl/cln_pkg.sv */
// cln_pkg: shared types, constants and helper functions for the character
// lcd nibble writer. No dependencies.
`default_nettype none
package cln_pkg;

   localparam int LINE_CHARS = 20;
   localparam int LINE_NIB_TOTAL = 2 * (LINE_CHARS + 2);
   localparam int LINE_IDX_LAST = LINE_CHARS + 1;
   localparam int INIT_NIBBLES = 8;
   localparam int CNT_W = ($clog2(LINE_NIB_TOTAL) > 3) ? $clog2(LINE_NIB_TOTAL) : 3;

   localparam int FIFO_DEPTH = 2;
   localparam int FIFO_PTR_W = 1;
   localparam int FIFO_CNT_W = 2;

   localparam logic [7:0] SPACE_CHAR = 8'h20;
   localparam logic [7:0] CMD_CLEAR = 8'h01;
   localparam logic [7:0] CMD_DISPLAY_ON = 8'h0F;
   localparam logic [7:0] ASCII_ZERO = 8'h30;
   localparam logic [7:0] ASCII_UPPER_A = 8'h41;
   localparam logic [3:0] NIB_WAKE = 4'h3;
   localparam logic [3:0] NIB_FOUR_BIT = 4'h2;
   localparam logic [2:0] GAP_HIGH = 3'd0;
   localparam logic [2:0] GAP_LOW = 3'd1;
   localparam logic [2:0] GAP_INIT = 3'd5;

   typedef enum logic [2:0] {
      ACT_INIT = 3'd0,
      ACT_CHAR = 3'd1,
      ACT_COMMAND = 3'd2,
      ACT_CURSOR = 3'd3,
      ACT_DECIMAL = 3'd4,
      ACT_HEX = 3'd5,
      ACT_CLEAR_LINE = 3'd6,
      ACT_CLEAR_SCREEN = 3'd7
   } action_type;

   typedef enum logic [1:0] {
      JOB_INIT = 2'd0,
      JOB_BYTES = 2'd1,
      JOB_LINE = 2'd2
   } job_mode_type;

   typedef struct packed {
      action_type action;
      logic [7:0] value;
      logic [1:0] row;
      logic [4:0] column;
      logic [1:0] digit_count;
   } req_item_type;

   typedef struct packed {
      logic [3:0] nibble;
      logic reg_select;
      logic [2:0] gap_ms;
      logic last;
   } rsp_item_type;

   typedef struct packed {
      job_mode_type mode;
      logic reg_select;
      logic [1:0] byte_count;
      logic [2:0][7:0] data_bytes;
   } job_type;

   function automatic logic [7:0] line_base(input logic [1:0] row);
      logic [7:0] base;
      case (row)
         2'd0: base = 8'h80;
         2'd1: base = 8'hC0;
         2'd2: base = 8'h94;
         default: base = 8'hD4;
      endcase
      return base;
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] d);
      logic [7:0] ch;
      if (d < 4'd10) begin
         ch = {4'h0, d} + ASCII_ZERO;
      end else begin
         ch = {4'h0, d} - 8'd10 + ASCII_UPPER_A;
      end
      return ch;
   endfunction

endpackage
`default_nettype wire

/* hw/rtl/cln_front.sv */
// cln_front: accepts display requests and turns each into a compact job
// (mode, register select, up to three bytes). Depends on cln_pkg.
`default_nettype none
module cln_front (
   input  wire logic                  req_valid,
   input  wire cln_pkg::req_item_type req_item,
   input  wire logic                  queue_full,
   output logic                       req_ready,
   output logic                       push,
   output cln_pkg::job_type           job
);

   logic [13:0] hund_prod;
   logic [1:0]  hund;
   logic [6:0]  rem_hund;
   logic [14:0] tens_prod;
   logic [3:0]  tens;
   logic [3:0]  units;
   logic [1:0]  digits;

   assign req_ready = !queue_full;
   assign push = req_valid && !queue_full;

   // constant reciprocal division of the value by 100 and 10
   always_comb begin
      hund_prod = 14'(req_item.value) * 14'd41;
      hund = hund_prod[13:12];
      rem_hund = 7'(req_item.value - 8'(hund) * 8'd100);
      tens_prod = 15'(rem_hund) * 15'd205;
      tens = tens_prod[14:11];
      units = 4'(rem_hund - 7'(tens) * 7'd10);
      digits = (req_item.digit_count == 2'd0) ? 2'd1 : req_item.digit_count;
   end

   always_comb begin
      job.mode = cln_pkg::JOB_BYTES;
      job.reg_select = 1'b0;
      job.byte_count = 2'd1;
      job.data_bytes = '0;
      case (req_item.action)
         cln_pkg::ACT_INIT: begin
            job.mode = cln_pkg::JOB_INIT;
         end
         cln_pkg::ACT_CHAR: begin
            job.reg_select = 1'b1;
            job.data_bytes[0] = req_item.value;
         end
         cln_pkg::ACT_COMMAND: begin
            job.data_bytes[0] = req_item.value;
         end
         cln_pkg::ACT_CURSOR: begin
            job.data_bytes[0] = cln_pkg::line_base(req_item.row) + 8'(req_item.column);
         end
         cln_pkg::ACT_DECIMAL: begin
            job.reg_select = 1'b1;
            job.byte_count = digits;
            case (digits)
               2'd3: begin
                  job.data_bytes[0] = cln_pkg::hex_char(4'(hund));
                  job.data_bytes[1] = cln_pkg::hex_char(tens);
                  job.data_bytes[2] = cln_pkg::hex_char(units);
               end
               2'd2: begin
                  job.data_bytes[0] = cln_pkg::hex_char(tens);
                  job.data_bytes[1] = cln_pkg::hex_char(units);
               end
               default: begin
                  job.data_bytes[0] = cln_pkg::hex_char(units);
               end
            endcase
         end
         cln_pkg::ACT_HEX: begin
            job.reg_select = 1'b1;
            job.byte_count = 2'd2;
            job.data_bytes[0] = cln_pkg::hex_char(req_item.value[7:4]);
            job.data_bytes[1] = cln_pkg::hex_char(req_item.value[3:0]);
         end
         cln_pkg::ACT_CLEAR_LINE: begin
            job.mode = cln_pkg::JOB_LINE;
            job.data_bytes[0] = cln_pkg::line_base(req_item.row);
         end
         default: begin
            job.data_bytes[0] = cln_pkg::CMD_CLEAR;
         end
      endcase
   end

endmodule
`default_nettype wire

/* hw/rtl/cln_fifo.sv */
// cln_fifo: two-entry job queue between the request decoder and the
// nibble sequencer. Depends on cln_pkg.
`default_nettype none
module cln_fifo (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire cln_pkg::job_type push_job,
   input  wire logic             pop,
   output logic                  full,
   output logic                  head_valid,
   output cln_pkg::job_type      head_job
);

   cln_pkg::job_type                entry_ff [cln_pkg::FIFO_DEPTH];
   logic [cln_pkg::FIFO_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [cln_pkg::FIFO_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [cln_pkg::FIFO_CNT_W-1:0]  count_ff, count_in;

   assign full = (count_ff == cln_pkg::FIFO_CNT_W'(cln_pkg::FIFO_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push) else $error("queue push while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid) else $error("queue pop while empty");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= cln_pkg::FIFO_CNT_W'(cln_pkg::FIFO_DEPTH))
      else $error("queue count out of range");

endmodule
`default_nettype wire

/* hw/rtl/cln_back.sv */
// cln_back: walks the job at the queue head one nibble per cycle, while the output
// is not stalled, into a registered output stage. Depends on cln_pkg.
`default_nettype none
module cln_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             head_valid,
   input  wire cln_pkg::job_type head_job,
   output logic                  pop,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output cln_pkg::rsp_item_type rsp_item
);

   logic [cln_pkg::CNT_W-1:0]   cnt_ff, cnt_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   cln_pkg::rsp_item_type       rsp_item_ff, rsp_item_in;
   logic [cln_pkg::CNT_W-1:0]   total;
   logic [cln_pkg::CNT_W-2:0]   byte_idx;
   logic [7:0]                  cur_byte;
   logic                        cur_rs;
   logic                        advance;
   logic                        is_last;
   cln_pkg::rsp_item_type       gen;

   assign byte_idx = cnt_ff[cln_pkg::CNT_W-1:1];
   assign advance = head_valid && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      case (head_job.mode)
         cln_pkg::JOB_INIT: total = cln_pkg::CNT_W'(cln_pkg::INIT_NIBBLES);
         cln_pkg::JOB_LINE: total = cln_pkg::CNT_W'(cln_pkg::LINE_NIB_TOTAL);
         default: total = cln_pkg::CNT_W'({head_job.byte_count, 1'b0});
      endcase
      is_last = (cnt_ff == total - 1'b1);
   end

   always_comb begin
      cur_byte = head_job.data_bytes[0];
      cur_rs = head_job.reg_select;
      if (head_job.mode == cln_pkg::JOB_LINE) begin
         if (byte_idx == '0 || byte_idx == (cln_pkg::CNT_W-1)'(cln_pkg::LINE_IDX_LAST)) begin
            cur_rs = 1'b0;
         end else begin
            cur_byte = cln_pkg::SPACE_CHAR;
            cur_rs = 1'b1;
         end
      end else begin
         case (byte_idx[1:0])
            2'd1: cur_byte = head_job.data_bytes[1];
            2'd2: cur_byte = head_job.data_bytes[2];
            default: cur_byte = head_job.data_bytes[0];
         endcase
      end
   end

   always_comb begin
      gen.last = is_last;
      gen.reg_select = cur_rs;
      gen.nibble = cnt_ff[0] ? cur_byte[3:0] : cur_byte[7:4];
      gen.gap_ms = cnt_ff[0] ? cln_pkg::GAP_LOW : cln_pkg::GAP_HIGH;
      if (head_job.mode == cln_pkg::JOB_INIT) begin
         gen.reg_select = 1'b0;
         case (cnt_ff[2:0])
            3'd0, 3'd1, 3'd2: begin
               gen.nibble = cln_pkg::NIB_WAKE;
               gen.gap_ms = cln_pkg::GAP_INIT;
            end
            3'd3: begin
               gen.nibble = cln_pkg::NIB_FOUR_BIT;
               gen.gap_ms = cln_pkg::GAP_INIT;
            end
            3'd4: gen.nibble = cln_pkg::CMD_DISPLAY_ON[7:4];
            3'd5: gen.nibble = cln_pkg::CMD_DISPLAY_ON[3:0];
            3'd6: gen.nibble = cln_pkg::CMD_CLEAR[7:4];
            default: gen.nibble = cln_pkg::CMD_CLEAR[3:0];
         endcase
      end
   end

   always_comb begin
      cnt_in = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_item_in = rsp_item_ff;
      if (advance) begin
         cnt_in = is_last ? '0 : cnt_ff + 1'b1;
         rsp_valid_in = 1'b1;
         rsp_item_in = gen;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign pop = advance && is_last;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item = rsp_item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff <= rsp_item_in;
   end

   a_cnt_in_run: assert property (@(posedge clock) disable iff (reset)
      head_valid |-> cnt_ff < total) else $error("nibble counter past end of run");
   a_pop_on_last: assert property (@(posedge clock) disable iff (reset)
      pop |=> (rsp_valid && rsp_item.last)) else $error("job retired without last item");
   a_cnt_restart: assert property (@(posedge clock) disable iff (reset)
      pop |=> cnt_ff == '0) else $error("counter not cleared after run");

endmodule
`default_nettype wire

/* hw/rtl/char_lcd_nibble_writer.sv */
// char_lcd_nibble_writer: top level, decoder, job queue and nibble sequencer.
// Depends on cln_pkg, cln_front, cln_fifo, cln_back.
//
//   channel   direction  handshake              payload
//   req       in         req_valid/req_ready    req_item (req_item_type)
//   rsp       out        rsp_valid/rsp_ready    rsp_item (rsp_item_type)
//
// one nibble item leaves per cycle while not stalled, set by the single sequencer counter;
// a request yields two nibbles per byte, 8 for init and 44 for a line clear
// requests are taken each cycle while the two-entry job queue has room
// synchronous active-high reset empties the queue and the output stage
// either side may stall without losing or repeating an item
`default_nettype none
module char_lcd_nibble_writer (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire cln_pkg::req_item_type req_item,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output cln_pkg::rsp_item_type      rsp_item
);

   logic             push;
   logic             pop;
   logic             queue_full;
   logic             head_valid;
   cln_pkg::job_type push_job;
   cln_pkg::job_type head_job;

   cln_front u_front (
      .req_valid  (req_valid),
      .req_item   (req_item),
      .queue_full (queue_full),
      .req_ready  (req_ready),
      .push       (push),
      .job        (push_job)
   );

   cln_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .pop        (pop),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   cln_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_item   (rsp_item)
   );

endmodule
`default_nettype wire
